FILE: hdl/maze_flood_fill_navigator_macros.svh
// Assertion macros shared by the maze navigator RTL.
// Each macro expects clk and rst_n to be visible in the module that uses it.
`ifndef MAZE_FLOOD_FILL_NAVIGATOR_MACROS_SVH
`define MAZE_FLOOD_FILL_NAVIGATOR_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define MFFN_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// When the antecedent holds, the consequent holds in the following cycle.
`define MFFN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/mffn_pkg.sv
// Shared types and constants of the maze navigator.
// Used by the channel interfaces, the controller, the datapath and the top level.
`default_nettype none

package mffn_pkg;

    localparam int COORD_W  = 4;
    localparam int DIST_W   = 8;
    localparam int STATUS_W = 2;
    localparam int TURN_W   = 2;
    localparam int HEAD_W   = 2;
    localparam int PEAK_W   = 10;
    localparam int POPS_W   = 19;

    localparam logic [PEAK_W-1:0] PEAK_MAX   = 10'd1023;
    localparam logic [POPS_W-1:0] POP_LIMIT  = 19'd262144;
    localparam logic [DIST_W-1:0] DIST_MAX   = 8'd255;

    localparam logic ACTION_LOAD  = 1'b0;
    localparam logic ACTION_SENSE = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_LOADED  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_MOVED   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_GOAL    = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_TRAPPED = 2'd3;

    localparam logic [TURN_W-1:0] TURN_NONE  = 2'd0;
    localparam logic [TURN_W-1:0] TURN_LEFT  = 2'd1;
    localparam logic [TURN_W-1:0] TURN_RIGHT = 2'd2;
    localparam logic [TURN_W-1:0] TURN_ABOUT = 2'd3;

    localparam logic [HEAD_W-1:0] DIR_N = 2'd0;
    localparam logic [HEAD_W-1:0] DIR_E = 2'd1;
    localparam logic [HEAD_W-1:0] DIR_S = 2'd2;
    localparam logic [HEAD_W-1:0] DIR_W = 2'd3;

    // Neighbor scan order: west, east, south, north.
    localparam logic [1:0] NB_W = 2'd0;
    localparam logic [1:0] NB_E = 2'd1;
    localparam logic [1:0] NB_S = 2'd2;
    localparam logic [1:0] NB_N = 2'd3;

    typedef struct packed {
        logic                capture_in;
        logic                load_dist;
        logic                set_walls;
        logic                focus_mouse;
        logic                focus_pop;
        logic                rd_self;
        logic                cap_self;
        logic                rd_nb;
        logic                cap_nb;
        logic                scan_clear;
        logic [1:0]          nb_sel;
        logic                push_focus;
        logic                push_nb;
        logic                pop;
        logic                flush;
        logic                pops_clear;
        logic                write_focus;
        logic                move;
        logic                emit;
        logic [STATUS_W-1:0] emit_status;
    } mffn_cmd_t;

    typedef struct packed {
        logic req_action;
        logic self_zero;
        logic any_open;
        logic lower;
        logic changed;
        logic q_empty;
        logic pop_limit;
    } mffn_sts_t;

    function automatic logic [HEAD_W-1:0] nb_dir(input logic [1:0] k);
        logic [HEAD_W-1:0] d;
        case (k)
            NB_W:    d = DIR_W;
            NB_E:    d = DIR_E;
            NB_S:    d = DIR_S;
            default: d = DIR_N;
        endcase
        return d;
    endfunction

    function automatic logic [TURN_W-1:0] turn_of(input logic [HEAD_W-1:0] diff);
        logic [TURN_W-1:0] t;
        case (diff)
            2'd0:    t = TURN_NONE;
            2'd1:    t = TURN_RIGHT;
            2'd2:    t = TURN_ABOUT;
            default: t = TURN_LEFT;
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/mffn_in_if.sv
// Input channel of the maze navigator: valid, ready and one input item.
// Depends on mffn_pkg for field widths.
`default_nettype none

interface mffn_in_if;
    logic                                valid;
    logic                                ready;
    logic                                action;
    logic [mffn_pkg::COORD_W-1:0]        cell_x;
    logic [mffn_pkg::COORD_W-1:0]        cell_y;
    logic [mffn_pkg::DIST_W-1:0]         cell_distance;
    logic                                wall_left;
    logic                                wall_front;
    logic                                wall_right;

    modport source (
        output valid, action, cell_x, cell_y, cell_distance,
               wall_left, wall_front, wall_right,
        input  ready
    );
    modport sink (
        input  valid, action, cell_x, cell_y, cell_distance,
               wall_left, wall_front, wall_right,
        output ready
    );
endinterface

`default_nettype wire

FILE: hdl/mffn_out_if.sv
// Output channel of the maze navigator: valid, ready and one result item.
// Depends on mffn_pkg for field widths.
`default_nettype none

interface mffn_out_if;
    logic                                valid;
    logic                                ready;
    logic [mffn_pkg::STATUS_W-1:0]       status;
    logic [mffn_pkg::TURN_W-1:0]         turn;
    logic [mffn_pkg::HEAD_W-1:0]         heading;
    logic [mffn_pkg::COORD_W-1:0]        pos_x;
    logic [mffn_pkg::COORD_W-1:0]        pos_y;
    logic [mffn_pkg::PEAK_W-1:0]         queue_peak;
    logic                                queue_overflow;

    modport source (
        output valid, status, turn, heading, pos_x, pos_y, queue_peak, queue_overflow,
        input  ready
    );
    modport sink (
        input  valid, status, turn, heading, pos_x, pos_y, queue_peak, queue_overflow,
        output ready
    );
endinterface

`default_nettype wire

FILE: hdl/mffn_dp.sv
// Datapath of the maze navigator: distance memory, wall bits, mouse state,
// flood-fill queue and result register. Depends on mffn_pkg and the channel interfaces.
`default_nettype none

module mffn_dp #(
    parameter int GRID_SIZE   = 16,
    parameter int QUEUE_DEPTH = 512
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    mffn_in_if.sink                  req,
    mffn_out_if.source               rsp,
    input  wire mffn_pkg::mffn_cmd_t cmd,
    output mffn_pkg::mffn_sts_t      sts
);

    `include "maze_flood_fill_navigator_macros.svh"

    localparam int XW = $clog2(GRID_SIZE);
    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW = (CW > mffn_pkg::PEAK_W) ? CW : mffn_pkg::PEAK_W;
    localparam logic [XW-1:0] XMAX = XW'(GRID_SIZE - 1);

    logic [mffn_pkg::DIST_W-1:0] dist_mem [GRID_SIZE][GRID_SIZE];
    logic                        dist_vld_reg [GRID_SIZE][GRID_SIZE];
    logic                        east_reg [GRID_SIZE][GRID_SIZE];
    logic                        north_reg [GRID_SIZE][GRID_SIZE];
    logic [2*XW-1:0]             q_mem [QUEUE_DEPTH];

    logic [mffn_pkg::COORD_W-1:0] ld_x_reg, ld_y_reg;
    logic [mffn_pkg::DIST_W-1:0]  ld_d_reg;
    logic                         wl_reg, wf_reg, wr_reg;

    logic [XW-1:0]                fx_reg, fy_reg, mx_reg, my_reg;
    logic [mffn_pkg::HEAD_W-1:0]  hd_reg;
    logic [mffn_pkg::TURN_W-1:0]  turn_reg;

    logic [mffn_pkg::DIST_W-1:0]  rd_data_reg;
    logic                         rd_vld_reg;
    logic [mffn_pkg::DIST_W-1:0]  self_d_reg, best_d_reg;
    logic                         found_reg;
    logic [1:0]                   best_k_reg;
    logic [3:0]                   nb_open_reg;

    logic [QW-1:0]                head_reg, tail_reg;
    logic [CW-1:0]                count_reg;
    logic [mffn_pkg::PEAK_W-1:0]  peak_reg;
    logic                         ovf_reg;
    logic [mffn_pkg::POPS_W-1:0]  pops_reg;
    logic [2*XW-1:0]              q_rd_reg;

    logic [mffn_pkg::STATUS_W-1:0] res_status_reg;
    logic [mffn_pkg::TURN_W-1:0]   res_turn_reg;
    logic [mffn_pkg::HEAD_W-1:0]   res_heading_reg;
    logic [mffn_pkg::COORD_W-1:0]  res_x_reg, res_y_reg;
    logic [mffn_pkg::PEAK_W-1:0]   res_peak_reg;
    logic                          res_ovf_reg;

    logic [XW-1:0]               nb_x [4];
    logic [XW-1:0]               nb_y [4];
    logic [3:0]                  nb_open_next;
    logic [mffn_pkg::DIST_W-1:0] dist_q, nv;
    logic [XW-1:0]               rx, ry, wx, wy;
    logic [mffn_pkg::DIST_W-1:0] wd;
    logic                        ld_in_range, we, rd_en;
    logic [3:0]                  wall_dir;
    logic [mffn_pkg::HEAD_W-1:0] mv_dir;
    logic [2*XW-1:0]             push_data;
    logic                        do_push, q_full;
    logic [QW-1:0]               tail_inc, head_inc;
    logic [CW-1:0]               cnt_inc;
    logic [EW-1:0]               cnt_ext;
    logic [mffn_pkg::PEAK_W-1:0] peak_new;

    assign nb_x[0] = fx_reg - 1'b1;
    assign nb_y[0] = fy_reg;
    assign nb_x[1] = fx_reg + 1'b1;
    assign nb_y[1] = fy_reg;
    assign nb_x[2] = fx_reg;
    assign nb_y[2] = fy_reg - 1'b1;
    assign nb_x[3] = fx_reg;
    assign nb_y[3] = fy_reg + 1'b1;

    always_comb
    begin
        nb_open_next[0] = (fx_reg != '0)   ? !east_reg[nb_x[0]][fy_reg]  : 1'b0;
        nb_open_next[1] = (fx_reg != XMAX) ? !east_reg[fx_reg][fy_reg]   : 1'b0;
        nb_open_next[2] = (fy_reg != '0)   ? !north_reg[fx_reg][nb_y[2]] : 1'b0;
        nb_open_next[3] = (fy_reg != XMAX) ? !north_reg[fx_reg][fy_reg]  : 1'b0;
    end

    assign dist_q = rd_vld_reg ? rd_data_reg : '0;
    assign nv     = (best_d_reg == mffn_pkg::DIST_MAX) ? mffn_pkg::DIST_MAX
                                                        : best_d_reg + 1'b1;

    assign ld_in_range = ({1'b0, ld_x_reg} < (mffn_pkg::COORD_W + 1)'(GRID_SIZE))
                      && ({1'b0, ld_y_reg} < (mffn_pkg::COORD_W + 1)'(GRID_SIZE));
    assign we    = (cmd.load_dist && ld_in_range) || cmd.write_focus;
    assign wx    = cmd.load_dist ? ld_x_reg[XW-1:0] : fx_reg;
    assign wy    = cmd.load_dist ? ld_y_reg[XW-1:0] : fy_reg;
    assign wd    = cmd.load_dist ? ld_d_reg : nv;
    assign rd_en = cmd.rd_self || cmd.rd_nb;
    assign rx    = cmd.rd_nb ? nb_x[cmd.nb_sel] : fx_reg;
    assign ry    = cmd.rd_nb ? nb_y[cmd.nb_sel] : fy_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            dist_mem[wx][wy] <= wd;
        end
        if (rd_en)
        begin
            rd_data_reg <= dist_mem[rx][ry];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dist_vld_reg <= '{default: '0};
            rd_vld_reg   <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                dist_vld_reg[wx][wy] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= dist_vld_reg[rx][ry];
            end
        end
    end

    assign wall_dir = (4'(wl_reg) << (hd_reg + 2'd3))
                    | (4'(wf_reg) << hd_reg)
                    | (4'(wr_reg) << (hd_reg + 2'd1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            east_reg  <= '{default: '0};
            north_reg <= '{default: '0};
        end
        else if (cmd.set_walls)
        begin
            if (wall_dir[mffn_pkg::DIR_N] && my_reg != XMAX)
            begin
                north_reg[mx_reg][my_reg] <= 1'b1;
            end
            if (wall_dir[mffn_pkg::DIR_E] && mx_reg != XMAX)
            begin
                east_reg[mx_reg][my_reg] <= 1'b1;
            end
            if (wall_dir[mffn_pkg::DIR_S] && my_reg != '0)
            begin
                north_reg[mx_reg][my_reg - 1'b1] <= 1'b1;
            end
            if (wall_dir[mffn_pkg::DIR_W] && mx_reg != '0)
            begin
                east_reg[mx_reg - 1'b1][my_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture_in)
        begin
            ld_x_reg <= req.cell_x;
            ld_y_reg <= req.cell_y;
            ld_d_reg <= req.cell_distance;
            wl_reg   <= req.wall_left;
            wf_reg   <= req.wall_front;
            wr_reg   <= req.wall_right;
        end
        if (cmd.focus_mouse)
        begin
            fx_reg <= mx_reg;
            fy_reg <= my_reg;
        end
        else if (cmd.focus_pop)
        begin
            {fx_reg, fy_reg} <= q_rd_reg;
        end
        if (cmd.rd_self)
        begin
            nb_open_reg <= nb_open_next;
        end
        if (cmd.cap_self)
        begin
            self_d_reg <= dist_q;
        end
        if (cmd.cap_nb && nb_open_reg[cmd.nb_sel] && (!found_reg || dist_q < best_d_reg))
        begin
            best_d_reg <= dist_q;
            best_k_reg <= cmd.nb_sel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (cmd.scan_clear)
        begin
            found_reg <= 1'b0;
        end
        else if (cmd.cap_nb && nb_open_reg[cmd.nb_sel])
        begin
            found_reg <= 1'b1;
        end
    end

    assign mv_dir = mffn_pkg::nb_dir(best_k_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mx_reg   <= '0;
            my_reg   <= '0;
            hd_reg   <= mffn_pkg::DIR_N;
            turn_reg <= mffn_pkg::TURN_NONE;
        end
        else if (cmd.move)
        begin
            mx_reg   <= nb_x[best_k_reg];
            my_reg   <= nb_y[best_k_reg];
            hd_reg   <= mv_dir;
            turn_reg <= mffn_pkg::turn_of(mv_dir - hd_reg);
        end
    end

    assign push_data = cmd.push_focus ? {fx_reg, fy_reg}
                                      : {nb_x[cmd.nb_sel], nb_y[cmd.nb_sel]};
    assign do_push   = cmd.push_focus || (cmd.push_nb && nb_open_reg[cmd.nb_sel]);
    assign q_full    = (count_reg == CW'(QUEUE_DEPTH));
    assign tail_inc  = (tail_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
    assign head_inc  = (head_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign cnt_inc   = count_reg + 1'b1;
    assign cnt_ext   = EW'(cnt_inc);
    assign peak_new  = (cnt_ext > EW'(mffn_pkg::PEAK_MAX)) ? mffn_pkg::PEAK_MAX
                                                           : cnt_ext[mffn_pkg::PEAK_W-1:0];

    always_ff @(posedge clk)
    begin
        if (do_push && !q_full)
        begin
            q_mem[tail_reg] <= push_data;
        end
        if (cmd.pop)
        begin
            q_rd_reg <= q_mem[head_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            peak_reg  <= '0;
            ovf_reg   <= 1'b0;
            pops_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                if (q_full)
                begin
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    tail_reg  <= tail_inc;
                    count_reg <= cnt_inc;
                    if (cnt_ext > EW'(peak_reg))
                    begin
                        peak_reg <= peak_new;
                    end
                end
            end
            else if (cmd.pop)
            begin
                head_reg  <= head_inc;
                count_reg <= count_reg - 1'b1;
            end
            else if (cmd.flush)
            begin
                head_reg  <= tail_reg;
                count_reg <= '0;
            end
            if (cmd.pops_clear)
            begin
                pops_reg <= '0;
            end
            else if (cmd.pop)
            begin
                pops_reg <= pops_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            res_status_reg  <= cmd.emit_status;
            res_turn_reg    <= (cmd.emit_status == mffn_pkg::STATUS_MOVED)
                               ? turn_reg : mffn_pkg::TURN_NONE;
            res_heading_reg <= hd_reg;
            res_x_reg       <= mffn_pkg::COORD_W'(mx_reg);
            res_y_reg       <= mffn_pkg::COORD_W'(my_reg);
            res_peak_reg    <= peak_reg;
            res_ovf_reg     <= ovf_reg;
        end
    end

    assign rsp.status         = res_status_reg;
    assign rsp.turn           = res_turn_reg;
    assign rsp.heading        = res_heading_reg;
    assign rsp.pos_x          = res_x_reg;
    assign rsp.pos_y          = res_y_reg;
    assign rsp.queue_peak     = res_peak_reg;
    assign rsp.queue_overflow = res_ovf_reg;

    always_comb
    begin
        sts.req_action = req.action;
        sts.self_zero  = (self_d_reg == '0);
        sts.any_open   = |nb_open_reg;
        sts.lower      = found_reg && (self_d_reg > best_d_reg);
        sts.changed    = (self_d_reg != nv);
        sts.q_empty    = (count_reg == '0);
        sts.pop_limit  = (pops_reg >= mffn_pkg::POP_LIMIT);
    end

    `MFFN_ASSERT_ALWAYS(a_count_bound, count_reg <= CW'(QUEUE_DEPTH), "queue count above depth")
    `MFFN_ASSERT_ALWAYS(a_empty_ptrs, (count_reg != '0) || (head_reg == tail_reg),
                        "empty queue with unequal pointers")
    `MFFN_ASSERT_ALWAYS(a_peak_cover, (EW'(count_reg) > EW'(mffn_pkg::PEAK_MAX))
                        || (EW'(peak_reg) >= EW'(count_reg)), "peak below occupancy")
    `MFFN_ASSERT_NEXT(a_ovf_sticky, ovf_reg, ovf_reg, "overflow flag cleared")

endmodule

`default_nettype wire

FILE: hdl/mffn_ctrl.sv
// Controller of the maze navigator: sequences loads, wall updates, neighbor
// scans and the flood fill. Depends on mffn_pkg and the channel interfaces.
`default_nettype none

module mffn_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    mffn_in_if.sink                  req,
    mffn_out_if.source               rsp,
    output mffn_pkg::mffn_cmd_t      cmd,
    input  wire mffn_pkg::mffn_sts_t sts
);

    typedef enum logic [15:0] {
        S_IDLE      = 16'b0000_0000_0000_0001,
        S_LOAD      = 16'b0000_0000_0000_0010,
        S_WALLS     = 16'b0000_0000_0000_0100,
        S_EV_FOCUS  = 16'b0000_0000_0000_1000,
        S_RD_SELF   = 16'b0000_0000_0001_0000,
        S_CAP_SELF  = 16'b0000_0000_0010_0000,
        S_SELF_CHK  = 16'b0000_0000_0100_0000,
        S_RD_NB     = 16'b0000_0000_1000_0000,
        S_CAP_NB    = 16'b0000_0001_0000_0000,
        S_EV_DECIDE = 16'b0000_0010_0000_0000,
        S_FL_START  = 16'b0000_0100_0000_0000,
        S_FL_CHECK  = 16'b0000_1000_0000_0000,
        S_FL_FOCUS  = 16'b0001_0000_0000_0000,
        S_FL_UPDATE = 16'b0010_0000_0000_0000,
        S_FL_PUSH   = 16'b0100_0000_0000_0000,
        S_FINISH    = 16'b1000_0000_0000_0000
    } state_t;

    state_t                        state_reg, state_next;
    logic                          flood_reg, flood_next;
    logic                          pass2_reg, pass2_next;
    logic [1:0]                    nb_cnt_reg, nb_cnt_next;
    logic                          out_valid_reg, out_valid_next;
    logic [mffn_pkg::STATUS_W-1:0] fin_reg, fin_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            flood_reg     <= 1'b0;
            pass2_reg     <= 1'b0;
            nb_cnt_reg    <= '0;
            out_valid_reg <= 1'b0;
            fin_reg       <= mffn_pkg::STATUS_LOADED;
        end
        else
        begin
            state_reg     <= state_next;
            flood_reg     <= flood_next;
            pass2_reg     <= pass2_next;
            nb_cnt_reg    <= nb_cnt_next;
            out_valid_reg <= out_valid_next;
            fin_reg       <= fin_next;
        end
    end

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = out_valid_reg;

    always_comb
    begin
        state_next  = state_reg;
        flood_next  = flood_reg;
        pass2_next  = pass2_reg;
        nb_cnt_next = nb_cnt_reg;
        fin_next    = fin_reg;
        cmd         = '0;
        cmd.nb_sel  = nb_cnt_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    cmd.capture_in = 1'b1;
                    state_next = (sts.req_action == mffn_pkg::ACTION_SENSE) ? S_WALLS : S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.load_dist = 1'b1;
                fin_next      = mffn_pkg::STATUS_LOADED;
                state_next    = S_FINISH;
            end
            S_WALLS:
            begin
                cmd.set_walls = 1'b1;
                pass2_next    = 1'b0;
                state_next    = S_EV_FOCUS;
            end
            S_EV_FOCUS:
            begin
                cmd.focus_mouse = 1'b1;
                flood_next      = 1'b0;
                state_next      = S_RD_SELF;
            end
            S_RD_SELF:
            begin
                cmd.rd_self    = 1'b1;
                cmd.scan_clear = 1'b1;
                state_next     = S_CAP_SELF;
            end
            S_CAP_SELF:
            begin
                cmd.cap_self = 1'b1;
                state_next   = S_SELF_CHK;
            end
            S_SELF_CHK:
            begin
                nb_cnt_next = '0;
                if (flood_reg && (sts.self_zero || !sts.any_open))
                begin
                    state_next = S_FL_CHECK;
                end
                else
                begin
                    state_next = S_RD_NB;
                end
            end
            S_RD_NB:
            begin
                cmd.rd_nb  = 1'b1;
                state_next = S_CAP_NB;
            end
            S_CAP_NB:
            begin
                cmd.cap_nb = 1'b1;
                if (nb_cnt_reg == mffn_pkg::NB_N)
                begin
                    state_next = flood_reg ? S_FL_UPDATE : S_EV_DECIDE;
                end
                else
                begin
                    nb_cnt_next = nb_cnt_reg + 1'b1;
                    state_next  = S_RD_NB;
                end
            end
            S_EV_DECIDE:
            begin
                state_next = S_FINISH;
                if (sts.lower)
                begin
                    cmd.move = 1'b1;
                    fin_next = mffn_pkg::STATUS_MOVED;
                end
                else if (pass2_reg || !sts.any_open)
                begin
                    fin_next = mffn_pkg::STATUS_TRAPPED;
                end
                else if (sts.self_zero)
                begin
                    fin_next = mffn_pkg::STATUS_GOAL;
                end
                else
                begin
                    flood_next = 1'b1;
                    state_next = S_FL_START;
                end
                if (!pass2_reg && !sts.lower && sts.self_zero)
                begin
                    fin_next   = mffn_pkg::STATUS_GOAL;
                    state_next = S_FINISH;
                end
            end
            S_FL_START:
            begin
                cmd.push_focus = 1'b1;
                cmd.pops_clear = 1'b1;
                state_next     = S_FL_CHECK;
            end
            S_FL_CHECK:
            begin
                if (sts.q_empty)
                begin
                    pass2_next = 1'b1;
                    state_next = S_EV_FOCUS;
                end
                else if (sts.pop_limit)
                begin
                    cmd.flush  = 1'b1;
                    pass2_next = 1'b1;
                    state_next = S_EV_FOCUS;
                end
                else
                begin
                    cmd.pop    = 1'b1;
                    state_next = S_FL_FOCUS;
                end
            end
            S_FL_FOCUS:
            begin
                cmd.focus_pop = 1'b1;
                state_next    = S_RD_SELF;
            end
            S_FL_UPDATE:
            begin
                nb_cnt_next = '0;
                if (sts.changed)
                begin
                    cmd.write_focus = 1'b1;
                    state_next      = S_FL_PUSH;
                end
                else
                begin
                    state_next = S_FL_CHECK;
                end
            end
            S_FL_PUSH:
            begin
                cmd.push_nb = 1'b1;
                if (nb_cnt_reg == mffn_pkg::NB_N)
                begin
                    state_next = S_FL_CHECK;
                end
                else
                begin
                    nb_cnt_next = nb_cnt_reg + 1'b1;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = fin_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/maze_flood_fill_navigator.sv
// Top level of the maze navigator: controller and datapath joined by command
// and status structs. Depends on mffn_pkg, mffn_in_if, mffn_out_if, mffn_ctrl, mffn_dp.
//
//   Channel | Direction | Item
//   req     | in        | load of one cell distance, or one sense step with wall flags
//   rsp     | out       | status, turn, heading, position, queue peak and overflow
//
// A load item is written in its load state and its result emitted in the finish state; a sense
// step sets the walls and evaluates the mouse cell, reading the distance memory through its
// single read port once for the cell and once for each of the four neighbors.
// A flood fill pushes the mouse cell, then pops cells: one at zero or with no open side is
// skipped, any other has its neighbors read and, if changed, is rewritten and its open
// neighbors pushed; a second evaluation follows. It is bounded by the limit of 262144 pops.
// Reset is asynchronous and clears maze, mouse and queue state at once.
// One item is in work at a time; a result not taken holds the next item in its finish state.
`default_nettype none

module maze_flood_fill_navigator #(
    parameter int GRID_SIZE   = 16,
    parameter int QUEUE_DEPTH = 512
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    mffn_in_if.sink    req,
    mffn_out_if.source rsp
);

    mffn_pkg::mffn_cmd_t cmd;
    mffn_pkg::mffn_sts_t sts;

    mffn_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cmd   (cmd),
        .sts   (sts)
    );

    mffn_dp #(
        .GRID_SIZE   (GRID_SIZE),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cmd   (cmd),
        .sts   (sts)
    );

endmodule

`default_nettype wire
